/* sv/sks_pkg.sv */
// Shared types and constants of the stable key insertion sorter.
`timescale 1ns / 1ps

package sks_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_W    = 8;
  localparam int POS_W    = 4;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } sks_entry_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       ins;    // insert ent into the chain
    logic       drain;  // shift the chain one place toward cell 0
    sks_entry_t ent;    // item being inserted
  } sks_ctl_t;

endpackage

/* sv/sks_ifs.sv */
// Valid/ready channel interfaces of the sorter.
`timescale 1ns / 1ps

interface sks_in_if import sks_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             last;

  modport source (output valid, key, last, input ready);
  modport sink   (input valid, key, last, output ready);
endinterface

interface sks_out_if import sks_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] origin_position;
  logic [KEY_W-1:0] sorted_key;
  logic             final_res;
  logic             overflowed;

  modport source (output valid, origin_position, sorted_key, final_res, overflowed,
                  input ready);
  modport sink   (input valid, origin_position, sorted_key, final_res, overflowed,
                  output ready);
endinterface

/* sv/stable_key_insertion_sorter.sv */
// Stable insertion sorter: top level with sequencer, cell chain and output register.
// Load: one key per cycle; each transfer is registered into the cell chain unless it is full.
// Drain: after a last item, one result per cycle from cell 0 while the output is not stalled,
//   n results for n keys; the drain state is registered, then cell 0 moves to the output register.
// Input is not accepted during the drain, so a new list loads only after every held key
//   of the last list has moved into the output register.
// Reset (rst_n, synchronous, active low) empties the chain, clears overflow and output valid.
`timescale 1ns / 1ps

module stable_key_insertion_sorter import sks_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  sks_in_if.sink           in_ch,
  sks_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;   // keys held; counts down while draining
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r, out_valid_nxt;
  sks_entry_t        out_ent_r;
  logic              out_final_r;
  logic              out_ovf_r;

  logic              in_xfer;
  logic              full;
  logic              drain_fire;
  sks_ctl_t          ctl;

  sks_entry_t        cell_ent [MAX_KEYS];
  logic [MAX_KEYS-1:0] cell_gt;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(MAX_KEYS));

  // Drain moves cell 0 into the output register whenever it is free or being emptied.
  assign drain_fire  = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);

  assign ctl.ins     = in_xfer && !full;
  assign ctl.drain   = drain_fire;
  assign ctl.ent.key = in_ch.key;
  assign ctl.ent.pos = POS_W'(count_r);   // arrival position, modulo 16

  // Cell chain: cell i is occupied when i < count.
  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic       left_gt;
    sks_entry_t left_ent;
    sks_entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_ent = '0;
    end else begin : g_mid
      assign left_gt  = cell_gt[i-1];
      assign left_ent = cell_ent[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_ent[i+1];
    end

    sks_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (IDX < count_r),
      .left_gt   (left_gt),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .gt        (cell_gt[i])
    );
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          // a list always holds at least one key when its last item lands
          if (in_ch.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_fire) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output register parts the chain from the result channel.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (drain_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_fire) begin
      out_ent_r   <= cell_ent[0];
      out_final_r <= (count_r == CNT_W'(1));
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.origin_position = out_ent_r.pos;
  assign out_ch.sorted_key      = out_ent_r.key;
  assign out_ch.final_res       = out_final_r;
  assign out_ch.overflowed      = out_ovf_r;

endmodule

/* sv/sks_cell.sv */
// One cell of the insertion chain: holds one key and its arrival position.
`timescale 1ns / 1ps

module sks_cell import sks_pkg::*; (
  input  logic       clk,
  input  sks_ctl_t   ctl,
  input  logic       occ,        // cell holds a key
  input  logic       left_gt,    // left neighbor also yields to the new key
  input  sks_entry_t left_ent,
  input  sks_entry_t right_ent,
  output sks_entry_t ent,
  output logic       gt
);

  sks_entry_t ent_r, ent_nxt;

  // strictly greater -> new key goes ahead of this one (stable for equal keys)
  assign gt  = !occ || (ent_r.key > ctl.ent.key);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.drain) begin
      ent_nxt = right_ent;
    end else if (ctl.ins && gt) begin
      ent_nxt = left_gt ? left_ent : ctl.ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
